@@ rtl/ips_pkg.sv @@
package ips_pkg;

  // Field widths.
  localparam int BYTE_W  = 8;
  localparam int SIZE_W  = 32;
  localparam int FLAG_W  = 9;
  localparam int SCORE_W = 7;
  localparam int VERD_W  = 2;

  // Flag bit positions.
  localparam int FLAG_OVERSIZED = 6;
  localparam int FLAG_CONTROL   = 7;
  localparam int FLAG_MULTI     = 8;
  localparam int NUM_CATS       = 6;
  localparam int MULTI_MIN      = 3;

  // Verdict codes.
  localparam logic [VERD_W-1:0] VERDICT_ALLOW   = 2'd0;
  localparam logic [VERD_W-1:0] VERDICT_OBSERVE = 2'd1;
  localparam logic [VERD_W-1:0] VERDICT_BLOCK   = 2'd2;

  localparam logic [SCORE_W-1:0] SCORE_MAX     = 7'd99;
  localparam logic [SCORE_W-1:0] SCORE_OBSERVE = 7'd30;
  localparam logic [SCORE_W-1:0] SCORE_BLOCK   = 7'd65;

  // Flag weights in hundredths, indexed by flag bit.
  localparam logic [SCORE_W-1:0] FLAG_WEIGHT [FLAG_W] =
    '{7'd32, 7'd36, 7'd34, 7'd24, 7'd30, 7'd12, 7'd18, 7'd25, 7'd18};

  // Control bytes that are not flagged; space, upper-case bounds and case offset.
  localparam logic [BYTE_W-1:0] CHAR_TAB = 8'd9;
  localparam logic [BYTE_W-1:0] CHAR_LF  = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_CR  = 8'd13;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] CHAR_UC_A  = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

  // Pattern table. Each pattern character is one cell in the chain.
  localparam int NUM_PATTERNS = 23;
  localparam int NUM_CELLS    = 190;

  localparam int PAT_LEN [NUM_PATTERNS] =
    '{10, 12, 7, 3, 10, 7, 7, 2, 15, 24, 10, 7, 3, 3, 3, 3, 7, 11, 8, 7, 12, 11, 8};
  localparam int PAT_CAT [NUM_PATTERNS] =
    '{0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 2, 2, 3, 3, 3, 3, 4, 4, 4, 5, 5, 5, 5};

  // All pattern characters back to back; the first character sits in the top byte.
  localparam logic [NUM_CELLS*BYTE_W-1:0] PAT_CHARS = {
    "drop table", "union select", " or 1=1", "'--",
    "powershell", "cmd.exe", "/bin/sh", "&&",
    "169.254.169.254", "metadata.google.internal", "localhost:", "file://",
    "../", "..\\", "%2e", "%2f",
    "<script", "javascript:", "onerror=",
    "api_key", "access_", "token", "private_", "key", "password"
  };

  function automatic logic [NUM_CELLS-1:0] start_mask();
    logic [NUM_CELLS-1:0] m;
    int pos;
    m   = '0;
    pos = 0;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      m[pos] = 1'b1;
      pos += PAT_LEN[p];
    end
    return m;
  endfunction

  function automatic logic [NUM_CELLS-1:0] cat_end_mask(input int cat);
    logic [NUM_CELLS-1:0] m;
    int pos;
    m   = '0;
    pos = 0;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      pos += PAT_LEN[p];
      if (PAT_CAT[p] == cat) begin
        m[pos-1] = 1'b1;
      end
    end
    return m;
  endfunction

  localparam logic [NUM_CELLS-1:0] START_MASK = start_mask();
  localparam logic [NUM_CELLS-1:0] CAT_END_MASK [NUM_CATS] = '{
    cat_end_mask(0), cat_end_mask(1), cat_end_mask(2),
    cat_end_mask(3), cat_end_mask(4), cat_end_mask(5)
  };

  // What every cell sees in a cycle.
  typedef struct packed {
    logic              take;   // a byte transfers this cycle
    logic              clear;  // that byte ends the message
    logic [BYTE_W-1:0] lc;     // lower-cased byte
  } ips_step_t;

endpackage

@@ rtl/ips_msg_if.sv @@
interface ips_msg_if import ips_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic              last;

  modport source (output valid, output byte_value, output last, input ready);
  modport sink (input valid, input byte_value, input last, output ready);
endinterface

@@ rtl/ips_report_if.sv @@
interface ips_report_if import ips_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FLAG_W-1:0]  signal_flags;
  logic [SCORE_W-1:0] risk_score;
  logic [VERD_W-1:0]  verdict;
  logic               clean;

  modport source (output valid, output signal_flags, output risk_score,
                  output verdict, output clean, input ready);
  modport sink (input valid, input signal_flags, input risk_score,
                input verdict, input clean, output ready);
endinterface

@@ rtl/ips_cell.sv @@
// One pattern character: holds whether the pattern prefix ending here matched.
module ips_cell import ips_pkg::*; #(
  parameter logic [7:0] CHAR = 8'h00
) (
  input  logic      clk,
  input  logic      rst,
  input  ips_step_t step,
  input  logic      prev_match,
  output logic      match,
  output logic      fire
);

  assign fire = step.take && prev_match && (step.lc == CHAR);

  always_ff @(posedge clk) begin
    if (rst || (step.take && step.clear)) begin
      match <= 1'b0;
    end else if (step.take) begin
      match <= fire;
    end
  end

endmodule

@@ rtl/injection_pattern_scanner.sv @@
// Streaming scanner for injection patterns. Message bytes arrive on msg, one
// transfer per byte, with last marking the final byte; every message yields
// exactly one transfer on report, raised in the cycle after its final byte is
// taken. Bytes are lower-cased (A to Z only) and run past a chain of 190 cells,
// one per character of the 23 fixed patterns (sql, command, ssrf, traversal,
// script, secret). Each cell passes its match bit to its right neighbor every
// byte, so the whole chain advances together. Throughput is one byte per clock
// unless report is stalled. The report stage is a single register, and msg
// stays ready while that register is empty or being drained, so back-to-back
// messages stream without a gap. Control bytes below 32 other than tab, line
// feed and carriage return set the control flag. size_limit is to be written
// through cfg_we/cfg_data only while the block is idle, which the block does
// not enforce; zero turns the oversize check off. The COUNT_BITS-wide byte
// counter saturates, so very long messages are judged at its maximum.
module injection_pattern_scanner import ips_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_data,
  ips_msg_if.sink           msg,
  ips_report_if.source      report
);

  localparam int CMP_W = (COUNT_BITS > SIZE_W) ? COUNT_BITS : SIZE_W;

  logic [SIZE_W-1:0]     size_limit;
  logic [COUNT_BITS-1:0] byte_count;
  logic [COUNT_BITS-1:0] byte_count_next;
  logic [NUM_CATS-1:0]   category_hits;
  logic [NUM_CATS-1:0]   cat_now;
  logic                  control_seen;
  logic                  ctrl_now;
  logic                  accept;
  ips_step_t             step;

  logic [NUM_CELLS-1:0] match;
  logic [NUM_CELLS-1:0] fire;

  logic [FLAG_W-1:0]  flags;
  logic [3:0]         flag_count;
  logic [7:0]         score_sum;
  logic [SCORE_W-1:0] score;
  logic [VERD_W-1:0]  verdict_next;

  // The report register is the only stage after the chain; a byte can be
  // taken whenever that register is free or its content leaves this cycle.
  assign msg.ready = !report.valid || report.ready;
  assign accept    = msg.valid && msg.ready;

  always_comb begin
    step.take  = accept;
    step.clear = msg.last;
    if (msg.byte_value >= CHAR_UC_A && msg.byte_value <= CHAR_UC_Z) begin
      step.lc = msg.byte_value + CASE_OFFSET;
    end else begin
      step.lc = msg.byte_value;
    end
  end

  // The chain: a cell that opens a pattern always sees a matched prefix.
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    logic prev;
    if (START_MASK[i]) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = match[i-1];
    end
    ips_cell #(
      .CHAR(PAT_CHARS[(NUM_CELLS-1-i)*BYTE_W +: BYTE_W])
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .step      (step),
      .prev_match(prev),
      .match     (match[i]),
      .fire      (fire[i])
    );
  end

  // A category is hit when the last cell of any of its patterns fires.
  always_comb begin
    for (int c = 0; c < NUM_CATS; c++) begin
      cat_now[c] = |(fire & CAT_END_MASK[c]);
    end
  end

  assign ctrl_now = (msg.byte_value < CHAR_SPACE) && (msg.byte_value != CHAR_TAB) &&
                    (msg.byte_value != CHAR_LF) && (msg.byte_value != CHAR_CR);

  assign byte_count_next = (&byte_count) ? byte_count : byte_count + 1'b1;

  // Flags and score for the message that ends with the current byte.
  always_comb begin
    flags = '0;
    flags[NUM_CATS-1:0] = category_hits | cat_now;
    flags[FLAG_OVERSIZED] = (size_limit != '0) &&
      (CMP_W'(byte_count_next) > CMP_W'(size_limit));
    flags[FLAG_CONTROL] = control_seen || ctrl_now;

    flag_count = '0;
    for (int i = 0; i < FLAG_MULTI; i++) begin
      flag_count = flag_count + 4'(flags[i]);
    end
    flags[FLAG_MULTI] = (flag_count >= 4'(MULTI_MIN));

    score_sum = '0;
    for (int i = 0; i < FLAG_W; i++) begin
      if (flags[i]) begin
        score_sum = score_sum + {1'b0, FLAG_WEIGHT[i]};
      end
    end
    score = (score_sum > {1'b0, SCORE_MAX}) ? SCORE_MAX : score_sum[SCORE_W-1:0];

    if (score >= SCORE_BLOCK) begin
      verdict_next = VERDICT_BLOCK;
    end else if (score >= SCORE_OBSERVE) begin
      verdict_next = VERDICT_OBSERVE;
    end else begin
      verdict_next = VERDICT_ALLOW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_limit <= '0;
    end else if (cfg_we) begin
      size_limit <= cfg_data;
    end
  end

  // Per-message state, cleared when the final byte transfers.
  always_ff @(posedge clk) begin
    if (rst) begin
      category_hits <= '0;
      control_seen  <= 1'b0;
      byte_count    <= '0;
    end else if (accept) begin
      if (msg.last) begin
        category_hits <= '0;
        control_seen  <= 1'b0;
        byte_count    <= '0;
      end else begin
        category_hits <= category_hits | cat_now;
        control_seen  <= control_seen | ctrl_now;
        byte_count    <= byte_count_next;
      end
    end
  end

  // Report register.
  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (accept && msg.last) begin
      report.valid <= 1'b1;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && msg.last) begin
      report.signal_flags <= flags;
      report.risk_score   <= score;
      report.verdict      <= verdict_next;
      report.clean        <= (flags == '0);
    end
  end

endmodule

@@ rtl/ips_checker.sv @@
module ips_checker import ips_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               msg_valid,
  input logic               msg_ready,
  input logic               msg_last,
  input logic               report_valid,
  input logic               report_ready,
  input logic [FLAG_W-1:0]  flags,
  input logic [SCORE_W-1:0] score,
  input logic [VERD_W-1:0]  verdict,
  input logic               clean
);

  // A new report only follows the transfer of a final byte.
  a_report_after_last: assert property (@(posedge clk) disable iff (rst)
    (report_valid && !$past(report_valid && !report_ready)) |->
      $past(msg_valid && msg_ready && msg_last))
    else $error("report without a final byte");

  a_clean: assert property (@(posedge clk) disable iff (rst)
    report_valid |-> (clean == (flags == '0)))
    else $error("clean does not match flags");

  a_verdict: assert property (@(posedge clk) disable iff (rst)
    report_valid |-> ((score >= SCORE_BLOCK && verdict == VERDICT_BLOCK) ||
      (score < SCORE_BLOCK && score >= SCORE_OBSERVE && verdict == VERDICT_OBSERVE) ||
      (score < SCORE_OBSERVE && verdict == VERDICT_ALLOW)))
    else $error("verdict does not match score");

  a_multi: assert property (@(posedge clk) disable iff (rst)
    report_valid |-> ((flags[FLAG_MULTI] == ($countones(flags[FLAG_MULTI-1:0]) >= MULTI_MIN))
      && (score <= SCORE_MAX)))
    else $error("multi flag or score range wrong");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (report_valid && !report_ready) |=> (report_valid && $stable(flags) && $stable(score)))
    else $error("stalled report changed");

endmodule

bind injection_pattern_scanner ips_checker u_ips_checker (
  .clk         (clk),
  .rst         (rst),
  .msg_valid   (msg.valid),
  .msg_ready   (msg.ready),
  .msg_last    (msg.last),
  .report_valid(report.valid),
  .report_ready(report.ready),
  .flags       (report.signal_flags),
  .score       (report.risk_score),
  .verdict     (report.verdict),
  .clean       (report.clean)
);
